>>> rtl/keyed_handle_type_aggregator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed handle type aggregator
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef KEYED_HANDLE_TYPE_AGGREGATOR_CORE_DEFINES_SVH
`define KEYED_HANDLE_TYPE_AGGREGATOR_CORE_DEFINES_SVH

// check cons in the same cycle as ante
`define KHT_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kht assertion failed");

// check cons in the cycle after ante
`define KHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kht assertion failed");

`endif

>>> rtl/kht_pkg.sv
// ----------------------------------------------------------------------------
// kht_pkg
// Constants, codes and shared types of the keyed handle type aggregator.
// ----------------------------------------------------------------------------
package kht_pkg;

	localparam int MAX_ENTRIES = 512;
	localparam int LANES       = 32;
	localparam int ROWS        = MAX_ENTRIES / LANES;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int LANE_W      = $clog2(LANES);
	localparam int IDX_W       = ROW_W + LANE_W;
	localparam int CNT_W       = IDX_W + 1;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int TYPE_W   = 8;
	localparam int SLOT_W   = 9;
	localparam int STATUS_W = 2;
	localparam int MASK_W   = 55;
	localparam int RCNT_W   = 8;
	localparam int TOT_W    = 24;

	localparam logic [TYPE_W-1:0] TYPE_LIMIT = 8'd55;
	localparam logic [RCNT_W-1:0] RCNT_MAX   = 8'hFF;
	localparam logic [TOT_W-1:0]  TOT_MAX    = 24'hFF_FFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR,
		CMD_PRELOAD,
		CMD_RECORD,
		CMD_READ
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_FETCH,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} srch_req_t;

	typedef struct packed {
		logic             done;
		logic             hit;
		logic [IDX_W-1:0] slot;
	} srch_rsp_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] slot;
		logic [KEY_W-1:0] key;
	} key_wr_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [RCNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ent_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} ent_rd_t;

endpackage

>>> rtl/kht_req_if.sv
// ----------------------------------------------------------------------------
// kht_req_if
// Request channel: command beat with key, type index and slot.
// ----------------------------------------------------------------------------
interface kht_req_if import kht_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [KEY_W-1:0]  process_id;
	logic [TYPE_W-1:0] type_index;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, command, process_id, type_index, slot, input ready);
	modport sink (input valid, command, process_id, type_index, slot, output ready);
endinterface

>>> rtl/kht_rsp_if.sv
// ----------------------------------------------------------------------------
// kht_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface kht_rsp_if import kht_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   entry_slot;
	logic                was_present;
	logic [MASK_W-1:0]   type_mask;
	logic [RCNT_W-1:0]   record_count;
	logic [TOT_W-1:0]    unique_count;
	logic [TOT_W-1:0]    total_records;

	modport source (output valid, status, entry_slot, was_present, type_mask, record_count,
		unique_count, total_records, input ready);
	modport sink (input valid, status, entry_slot, was_present, type_mask, record_count,
		unique_count, total_records, output ready);
endinterface

>>> rtl/kht_key_search.sv
// ----------------------------------------------------------------------------
// kht_key_search
// Key memory in rows of LANES keys; scans one row per cycle and compares all
// lanes of the row against the search key. Keys in the table are unique.
// ----------------------------------------------------------------------------
module kht_key_search import kht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  srch_req_t req,
	output srch_rsp_t rsp,
	input  key_wr_t   wr
);

	logic [LANES-1:0][KEY_W-1:0] key_mem [ROWS];

	logic [KEY_W-1:0]            key_q;
	logic [CNT_W-1:0]            count_q;
	logic                        busy_q;
	logic [ROW_W-1:0]            row_q;
	logic                        vld_s1;
	logic [ROW_W-1:0]            row_s1;
	logic [LANES-1:0][KEY_W-1:0] data_s1;
	logic                        vld_s2;
	logic                        hit_s2;
	logic                        last_s2;
	logic [IDX_W-1:0]            slot_s2;

	logic [CNT_W-1:0]  cnt_m1;
	logic [ROW_W-1:0]  last_row;
	logic [LANES-1:0]  match;
	logic [LANE_W-1:0] lane_enc;
	logic              done;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign last_row = cnt_m1[IDX_W-1:LANE_W];
	assign done     = vld_s2 && (hit_s2 || last_s2);

	always_comb begin
		lane_enc = '0;
		for (int l = 0; l < LANES; l++) begin
			match[l] = (data_s1[l] == key_q) && ({1'b0, row_s1, LANE_W'(l)} < count_q);
			if (match[l]) begin
				lane_enc = lane_enc | LANE_W'(l);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.slot[IDX_W-1:LANE_W]][wr.slot[LANE_W-1:0]] <= wr.key;
		end
		data_s1 <= key_mem[row_q];
		row_s1  <= row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			row_q   <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			hit_s2  <= 1'b0;
			last_s2 <= 1'b0;
			slot_s2 <= '0;
		end else if (req.start) begin
			key_q   <= req.key;
			count_q <= req.count;
			row_q   <= '0;
			vld_s1  <= 1'b0;
			if (req.count == '0) begin
				busy_q  <= 1'b0;
				vld_s2  <= 1'b1;
				hit_s2  <= 1'b0;
				last_s2 <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				vld_s2 <= 1'b0;
			end
		end else if (done) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= busy_q;
			if (busy_q) begin
				if (row_q == last_row) begin
					busy_q <= 1'b0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
			vld_s2  <= vld_s1;
			hit_s2  <= |match;
			slot_s2 <= {row_s1, lane_enc};
			last_s2 <= (row_s1 == last_row);
		end
	end

	assign rsp = '{done: done, hit: hit_s2, slot: slot_s2};

endmodule

>>> rtl/kht_entry_store.sv
// ----------------------------------------------------------------------------
// kht_entry_store
// Per-entry type mask and record count; one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module kht_entry_store import kht_pkg::*; (
	input  logic    clk,
	input  ent_rd_t rd,
	output entry_t  rd_data,
	input  ent_wr_t wr
);

	entry_t mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

>>> rtl/keyed_handle_type_aggregator_core.sv
// ----------------------------------------------------------------------------
// keyed_handle_type_aggregator_core
// Process-keyed table of handle type masks and record counts.
// ----------------------------------------------------------------------------
// Usage: one request beat on req (clear, preload key, handle record, read
// slot) gives one result beat on rsp, in order. Both are valid/ready.
// Clear and read do not search; read takes one entry memory read. Preload
// and handle record scan the key memory one row of 32 keys a cycle over
// the filled rows only, ending at a hit; an empty table is not scanned. A
// hit adds an entry memory read (and for a handle record the write back).
// One request is in work at a time; req.ready is high while idle and rises
// on the edge that loads the result. The result sits in an output register,
// so the next request is taken while a result still waits; a stalled rsp
// holds the following result internally and then holds req.ready low.
// Reset empties the table and zeroes both running counters at once; the
// memories themselves are not swept, entries past the fill count are never
// returned.
// ----------------------------------------------------------------------------
`include "keyed_handle_type_aggregator_core_defines.svh"

module keyed_handle_type_aggregator_core import kht_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	kht_req_if.sink   req,
	kht_rsp_if.source rsp
);

	fsm_t state_q, state_d;

	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [TYPE_W-1:0] type_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic [TOT_W-1:0]  miss_q;
	logic [TOT_W-1:0]  total_q;

	status_t           res_status_q;
	logic [IDX_W-1:0]  res_slot_q;
	logic              res_present_q;
	logic [MASK_W-1:0] res_mask_q;
	logic [RCNT_W-1:0] res_count_q;

	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [IDX_W-1:0]    out_slot_q;
	logic                out_present_q;
	logic [MASK_W-1:0]   out_mask_q;
	logic [RCNT_W-1:0]   out_count_q;
	logic [TOT_W-1:0]    out_unique_q;
	logic [TOT_W-1:0]    out_total_q;

	srch_req_t srch_req;
	srch_rsp_t srch_rsp;
	key_wr_t   key_wr;
	ent_rd_t   ent_rd;
	ent_wr_t   ent_wr;
	entry_t    ent_rd_data;

	logic              accept;
	logic              room;
	logic              out_free;
	logic              read_ok;
	logic [MASK_W-1:0] type_bit;
	logic [MASK_W-1:0] rmw_mask;
	logic [RCNT_W-1:0] rmw_cnt;
	cmd_t              req_cmd;

	assign req_cmd  = cmd_t'(req.command);
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == FSM_IDLE);
	assign room     = entry_count_q < CNT_W'(MAX_ENTRIES);
	assign out_free = !out_vld_q || rsp.ready;
	assign read_ok  = CNT_W'(rslot_q) < entry_count_q;
	assign type_bit = (type_q < TYPE_LIMIT) ? (MASK_W'(1) << type_q[5:0]) : '0;
	assign rmw_mask = ent_rd_data.mask | type_bit;
	assign rmw_cnt  = (ent_rd_data.count == RCNT_MAX) ? ent_rd_data.count
		: ent_rd_data.count + RCNT_W'(1);

	kht_key_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (srch_req),
		.rsp    (srch_rsp),
		.wr     (key_wr)
	);

	kht_entry_store u_store (
		.clk     (clk),
		.rd      (ent_rd),
		.rd_data (ent_rd_data),
		.wr      (ent_wr)
	);

	always_comb begin
		state_d  = state_q;
		srch_req = '{start: accept && (req_cmd == CMD_PRELOAD || req_cmd == CMD_RECORD),
			key: req.process_id, count: entry_count_q};
		key_wr   = '0;
		ent_rd   = '0;
		ent_wr   = '0;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					case (req_cmd)
						CMD_CLEAR: state_d = FSM_DONE;
						CMD_PRELOAD, CMD_RECORD: state_d = FSM_SEARCH;
						CMD_READ: begin
							ent_rd.en   = 1'b1;
							ent_rd.addr = req.slot[IDX_W-1:0];
							state_d     = FSM_FETCH;
						end
						default: state_d = FSM_DONE;
					endcase
				end
			end
			FSM_SEARCH: begin
				if (srch_rsp.done) begin
					if (srch_rsp.hit) begin
						ent_rd.en   = 1'b1;
						ent_rd.addr = srch_rsp.slot;
						state_d     = FSM_FETCH;
					end else begin
						if (room) begin
							key_wr.en   = 1'b1;
							key_wr.slot = entry_count_q[IDX_W-1:0];
							key_wr.key  = key_q;
							ent_wr.en   = 1'b1;
							ent_wr.addr = entry_count_q[IDX_W-1:0];
							if (cmd_q == CMD_RECORD) begin
								ent_wr.data = '{mask: type_bit, count: RCNT_W'(1)};
							end
						end
						state_d = FSM_DONE;
					end
				end
			end
			FSM_FETCH: begin
				if (cmd_q == CMD_RECORD) begin
					ent_wr.en   = 1'b1;
					ent_wr.addr = res_slot_q;
					ent_wr.data = '{mask: rmw_mask, count: rmw_cnt};
				end
				state_d = FSM_DONE;
			end
			FSM_DONE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			miss_q        <= '0;
			total_q       <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						case (req_cmd)
							CMD_CLEAR: begin
								entry_count_q <= '0;
								miss_q        <= '0;
								total_q       <= '0;
							end
							CMD_RECORD: begin
								if (total_q != TOT_MAX) begin
									total_q <= total_q + TOT_W'(1);
								end
							end
							default: ;
						endcase
					end
				end
				FSM_SEARCH: begin
					if (srch_rsp.done && !srch_rsp.hit) begin
						if (cmd_q == CMD_RECORD && miss_q != TOT_MAX) begin
							miss_q <= miss_q + TOT_W'(1);
						end
						if (room) begin
							entry_count_q <= entry_count_q + CNT_W'(1);
						end
					end
				end
				FSM_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					cmd_q         <= req_cmd;
					key_q         <= req.process_id;
					type_q        <= req.type_index;
					rslot_q       <= req.slot;
					res_status_q  <= STAT_OK;
					res_slot_q    <= '0;
					res_present_q <= 1'b0;
					res_mask_q    <= '0;
					res_count_q   <= '0;
				end
			end
			FSM_SEARCH: begin
				if (srch_rsp.done) begin
					if (srch_rsp.hit) begin
						res_slot_q    <= srch_rsp.slot;
						res_present_q <= 1'b1;
					end else if (room) begin
						res_slot_q <= entry_count_q[IDX_W-1:0];
						if (cmd_q == CMD_RECORD) begin
							res_mask_q  <= type_bit;
							res_count_q <= RCNT_W'(1);
						end
					end else begin
						res_status_q <= STAT_FULL;
					end
				end
			end
			FSM_FETCH: begin
				if (cmd_q == CMD_READ) begin
					res_slot_q <= rslot_q[IDX_W-1:0];
					if (read_ok) begin
						res_present_q <= 1'b1;
						res_mask_q    <= ent_rd_data.mask;
						res_count_q   <= ent_rd_data.count;
					end else begin
						res_status_q <= STAT_EMPTY;
					end
				end else if (cmd_q == CMD_RECORD) begin
					res_mask_q  <= rmw_mask;
					res_count_q <= rmw_cnt;
				end else begin
					res_mask_q  <= ent_rd_data.mask;
					res_count_q <= ent_rd_data.count;
				end
			end
			FSM_DONE: begin
				if (out_free) begin
					out_status_q  <= res_status_q;
					out_slot_q    <= res_slot_q;
					out_present_q <= res_present_q;
					out_mask_q    <= res_mask_q;
					out_count_q   <= res_count_q;
					out_unique_q  <= miss_q;
					out_total_q   <= total_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.entry_slot    = SLOT_W'(out_slot_q);
	assign rsp.was_present   = out_present_q;
	assign rsp.type_mask     = out_mask_q;
	assign rsp.record_count  = out_count_q;
	assign rsp.unique_count  = out_unique_q;
	assign rsp.total_records = out_total_q;

	`KHT_ASSERT(a_count_bound, clk, arst_n, 1'b1, (entry_count_q <= CNT_W'(MAX_ENTRIES)))
	`KHT_ASSERT_NEXT(a_accept_busy, clk, arst_n, (req.valid && req.ready), (state_q != FSM_IDLE))
	`KHT_ASSERT(a_hit_in_range, clk, arst_n, (srch_rsp.done && srch_rsp.hit), ({1'b0, srch_rsp.slot} < entry_count_q))
	`KHT_ASSERT_NEXT(a_done_loads, clk, arst_n, (state_q == FSM_DONE && out_free), (rsp.valid))

endmodule
